### design/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console character writer: the
// item layouts of both channels, the operation codes, the controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS  = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STOP = 8;

  // Fixed field widths
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } tcw_op_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [7:0]       char_code;
    logic [3:0]       bg_color;
    logic [3:0]       fg_color;
    logic [IDX_W-1:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              did_scroll;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_RESET_CLR,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_CLEAR,
    ST_LOCATE,
    ST_READ,
    ST_RESULT
  } tcw_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic home;
    logic sweep_clr;
    logic sweep_all;
    logic sweep_row;
    logic put;
    logic locate;
    logic read;
    logic load_out;
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic all_done;
    logic row_done;
    logic scroll;
    logic out_free;
  } tcw_status_t;

endpackage
`default_nettype wire

### design/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console writer: takes one item at a time, steps the
// datapath through put, scroll, clear and read, and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [1:0]  in_op_i,
  input  wire tcw_status_t status_i,
  output logic             in_stall_o,
  output tcw_cmd_t         cmd_o
);

  tcw_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RESET_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RESET_CLR: begin
        if (status_i.all_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (tcw_op_e'(in_op_i))
            OP_PUT:   state_d = ST_PUT;
            OP_CLEAR: state_d = ST_CLEAR;
            OP_READ:  state_d = ST_LOCATE;
            OP_NOP:   state_d = ST_RESULT;
            default:  state_d = ST_RESULT;
          endcase
        end
      end
      ST_PUT: begin
        state_d = status_i.scroll ? ST_SCROLL : ST_RESULT;
      end
      ST_SCROLL: begin
        if (status_i.row_done) state_d = ST_RESULT;
      end
      ST_CLEAR: begin
        if (status_i.all_done) state_d = ST_RESULT;
      end
      ST_LOCATE: state_d = ST_READ;
      ST_READ:   state_d = ST_RESULT;
      ST_RESULT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      ST_RESET_CLR: cmd_o.sweep_all = 1'b1;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_op_i == OP_CLEAR) begin
            cmd_o.home      = 1'b1;
            cmd_o.sweep_clr = 1'b1;
          end
        end
      end
      ST_PUT: begin
        cmd_o.put       = 1'b1;
        cmd_o.sweep_clr = 1'b1;
      end
      ST_SCROLL: cmd_o.sweep_row = 1'b1;
      ST_CLEAR:  cmd_o.sweep_all = 1'b1;
      ST_LOCATE: cmd_o.locate    = 1'b1;
      ST_READ:   cmd_o.read      = 1'b1;
      ST_RESULT: cmd_o.load_out  = status_i.out_free;
      default:   cmd_o           = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor and row rotation of the console writer. Screen
// rows rotate through the memory: a scroll advances the top row pointer
// and blanks the physical row that becomes the bottom line.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ROWS     = DEF_ROWS,
  parameter int TAB_STOP = DEF_TAB_STOP
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tcw_cmd_t cmd_i,
  input  wire tcw_in_t  in_data_i,
  input  wire logic     out_stall_i,
  output tcw_status_t   status_o,
  output logic          out_valid_o,
  output tcw_out_t      out_data_o
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int TAB_W  = $clog2(TAB_STOP);
  localparam int CX_W   = COL_W + 2;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS << COL_W;
  localparam int WIDE_W = 13;

  localparam logic [WIDE_W-1:0] CELL_CNT   = WIDE_W'(ROWS * COLUMNS);
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Logical row plus top row pointer, modulo the row count
  function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] a,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ROW_W+1)'(ROWS)) s = s - (ROW_W+1)'(ROWS);
    return s[ROW_W-1:0];
  endfunction

  tcw_in_t           item_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [TAB_W-1:0]  mod_q;
  logic [ROW_W-1:0]  base_q;
  logic [ROW_W-1:0]  srow_q;
  logic [ADDR_W-1:0] sweep_q;
  logic              scroll_q;
  logic [ROW_W-1:0]  loc_row_q;
  logic [COL_W-1:0]  loc_col_q;
  logic              rd_ok_q;
  logic [CELL_W-1:0] rd_q;
  logic              out_valid_q;
  tcw_out_t          out_q;

  logic [CELL_W-1:0] mem [DEPTH];

  logic [CX_W-1:0]    p_col;
  logic [ROW_W:0]     p_row;
  logic [TAB_W-1:0]   p_mod;
  logic               put_draw;
  logic               put_scroll;
  logic [COL_W-1:0]   col_d;
  logic [ROW_W-1:0]   row_d;
  logic [ROW_W-1:0]   base_d;
  logic [ROW_W-1:0]   put_prow;
  logic [ROW_W-1:0]   loc_row_d;
  logic [COL_W-1:0]   loc_col_d;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [CELL_W-1:0]  mem_wd;
  logic [ADDR_W-1:0]  mem_ra;
  logic [WIDE_W-1:0]  pos_wide;
  tcw_out_t           out_d;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  // Cursor update for one put
  always_comb begin
    p_col    = {2'b00, col_q};
    p_row    = {1'b0, row_q};
    p_mod    = mod_q;
    put_draw = 1'b0;
    case (item_q.char_code)
      CH_BS: begin
        if (col_q != '0) begin
          p_col = p_col - 1'b1;
          p_mod = (mod_q == '0) ? TAB_W'(TAB_STOP - 1) : mod_q - 1'b1;
        end
      end
      CH_TAB: begin
        p_col = p_col + CX_W'(TAB_STOP) - CX_W'(mod_q);
        p_mod = '0;
      end
      CH_CR: begin
        p_col = '0;
        p_mod = '0;
      end
      CH_LF: begin
        p_col = '0;
        p_row = p_row + 1'b1;
        p_mod = '0;
      end
      default: begin
        if (item_q.char_code inside {[CH_SPACE:CH_DEL]}) begin
          put_draw = 1'b1;
          p_col    = p_col + 1'b1;
          p_mod    = (mod_q == TAB_W'(TAB_STOP - 1)) ? '0 : mod_q + 1'b1;
        end
      end
    endcase
    // Wrap past the right edge
    if (p_col >= CX_W'(COLUMNS)) begin
      p_col = '0;
      p_row = p_row + 1'b1;
      p_mod = '0;
    end
    put_scroll = (p_row >= (ROW_W+1)'(ROWS));
    col_d      = p_col[COL_W-1:0];
    row_d      = put_scroll ? ROW_W'(ROWS - 1) : p_row[ROW_W-1:0];
    base_d     = (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + 1'b1;
    put_prow   = wrap_row(row_q, base_q);
  end

  // Cursor and row rotation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      mod_q  <= '0;
      base_q <= '0;
    end else if (cmd_i.home) begin
      col_q  <= '0;
      row_q  <= '0;
      mod_q  <= '0;
      base_q <= '0;
    end else if (cmd_i.put) begin
      col_q <= col_d;
      row_q <= row_d;
      mod_q <= p_mod;
      if (put_scroll) base_q <= base_d;
    end
  end

  // Remember the physical row to blank and whether this put scrolled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_q <= 1'b0;
    end else if (cmd_i.capture) begin
      scroll_q <= 1'b0;
    end else if (cmd_i.put) begin
      scroll_q <= put_scroll;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put && put_scroll) srow_q <= base_q;
  end

  // Sweep counter for blanking passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_clr) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_all || cmd_i.sweep_row) begin
      sweep_q <= sweep_q + 1'b1;
    end
  end

  // Split the read index into row and column, one quotient bit a step
  always_comb begin
    logic [WIDE_W-1:0] rem;
    logic [WIDE_W-1:0] trial;
    rem       = {2'b00, item_q.cell_index};
    loc_row_d = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      trial = WIDE_W'(COLUMNS) << i;
      if (rem >= trial) begin
        rem          = rem - trial;
        loc_row_d[i] = 1'b1;
      end
    end
    loc_col_d = rem[COL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.locate) begin
      loc_row_q <= loc_row_d;
      loc_col_q <= loc_col_d;
      rd_ok_q   <= ({2'b00, item_q.cell_index} < CELL_CNT);
    end
  end

  // Memory write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_q;
    mem_wd = BLANK_CELL;
    if (cmd_i.sweep_all) begin
      mem_we = 1'b1;
    end else if (cmd_i.sweep_row) begin
      mem_we = 1'b1;
      mem_wa = {srow_q, sweep_q[COL_W-1:0]};
    end else if (cmd_i.put && put_draw) begin
      mem_we = 1'b1;
      mem_wa = {put_prow, col_q};
      mem_wd = {item_q.bg_color, item_q.fg_color, item_q.char_code};
    end
  end

  assign mem_ra = {wrap_row(loc_row_q, base_q), loc_col_q};

  // Screen memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) rd_q <= mem[mem_ra];
  end

  // Result assembly
  always_comb begin
    pos_wide              = WIDE_W'(row_q) * WIDE_W'(COLUMNS) + WIDE_W'(col_q);
    out_d.cursor_position = pos_wide[POS_W-1:0];
    out_d.cell_data       = (item_q.opcode == OP_READ && rd_ok_q) ? rd_q : '0;
    out_d.did_scroll      = scroll_q;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.all_done = (sweep_q == ADDR_W'(DEPTH - 1));
  assign status_o.row_done = (sweep_q[COL_W-1:0] == COL_W'(COLUMNS - 1));
  assign status_o.scroll   = put_scroll;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

### design/text_console_char_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_writer
// Flow: a put steps through PUT, then SCROLL if the cursor passes the
//   bottom line, then RESULT; a read through LOCATE, READ and RESULT; a
//   clear sweeps the whole screen memory in CLEAR; a no-op goes to RESULT.
// Items: one at a time; a new item is taken only once RESULT has loaded the last result.
// Reset: cursor homes and a blanking pass runs through the screen memory
//   while input is stalled.
// ----------------------------------------------------------------------------
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = DEF_COLUMNS,
  parameter int ROWS     = DEF_ROWS,
  parameter int TAB_STOP = DEF_TAB_STOP
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire tcw_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output tcw_out_t     out_data_o
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.opcode),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  localparam int CELLS = ROWS * COLUMNS;

  // An accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accept");

  // A new result only appears while an item is in work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in work");

  // The cursor always stays on screen
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (CELLS < 2048)) |->
      (out_data_o.cursor_position < POS_W'(CELLS)))
    else $error("cursor position off screen");

  // A scroll leaves the cursor on the bottom line
  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.did_scroll && (CELLS <= 2048)) |->
      (out_data_o.cursor_position >= POS_W'((ROWS - 1) * COLUMNS)))
    else $error("scroll left cursor above the bottom line");
`endif

endmodule
`default_nettype wire
